// ===== rtl/pafm_pkg.sv =====
package pafm_pkg;

    // operation codes
    localparam logic [1:0] FUNC_EVAL  = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // rule direction
    localparam logic [1:0] DIR_BOTH = 2'd2;

    // stored protocol classes
    localparam logic [1:0] CLS_ALL  = 2'd0;
    localparam logic [1:0] CLS_TCP  = 2'd1;
    localparam logic [1:0] CLS_UDP  = 2'd2;
    localparam logic [1:0] CLS_ICMP = 2'd3;

    // IPv4 protocol numbers
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    localparam logic [5:0] PREFIX_MAX = 6'd32;

    // rule flag bits
    localparam int FL_SRC_RANGE = 0;
    localparam int FL_DST_RANGE = 1;
    localparam int FL_DENY      = 2;

    // packet flag bits
    localparam int PF_IPV4 = 0;
    localparam int PF_L4   = 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port_low;
        logic [15:0] src_port_high;
        logic [15:0] dst_port_low;
        logic [15:0] dst_port_high;
        logic [1:0]  direction;
        logic [1:0]  proto_cls;
        logic [5:0]  src_prefix_len;
        logic [5:0]  dst_prefix_len;
        logic [2:0]  flags;
    } rule_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic rd_next;
        logic set_hit;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_eval;
        logic count_zero;
        logic match;
        logic scan_end;
        logic out_free;
    } sts_t;

    // length is saturated to 32 on write; 0 gives an all-zero mask
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        prefix_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

// ===== rtl/pafm_ram.sv =====
module pafm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/pafm_ctrl.sv =====
module pafm_ctrl
    import pafm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (sts.is_eval && !sts.count_zero) ? ST_EVAL : ST_DONE;
                end
            end
            ST_EVAL: begin
                if (sts.match || sts.scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_EVAL: begin
                // data on the RAM port is the rule before idx
                cmd.set_hit = sts.match;
                cmd.rd_next = !sts.match && !sts.scan_end;
            end
            ST_DONE: begin
                cmd.load_out = sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/pafm_dp.sv =====
module pafm_dp
    import pafm_pkg::*;
#(
    parameter int MAX_RULES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic [1:0]  s_func,
    input  logic [1:0]  s_direction,
    input  logic [7:0]  s_proto_code,
    input  logic [31:0] s_src_addr,
    input  logic [5:0]  s_src_prefix_len,
    input  logic [31:0] s_dst_addr,
    input  logic [5:0]  s_dst_prefix_len,
    input  logic [15:0] s_src_port_low,
    input  logic [15:0] s_src_port_high,
    input  logic [15:0] s_dst_port_low,
    input  logic [15:0] s_dst_port_high,
    input  logic [2:0]  s_flags,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_verdict,
    output logic        m_rule_hit,
    output logic        m_table_full,
    input  cmd_t        cmd,
    output sts_t        sts
);

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_RULES);

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          default_action_reg;

    // latched packet
    logic [1:0]  pkt_dir_reg;
    logic [7:0]  pkt_proto_reg;
    logic [31:0] pkt_sa_reg;
    logic [31:0] pkt_da_reg;
    logic [15:0] pkt_sp_reg;
    logic [15:0] pkt_dp_reg;
    logic [2:0]  pkt_fl_reg;

    logic res_verdict_reg, res_hit_reg, res_full_reg;
    logic m_valid_reg, m_verdict_reg, m_rule_hit_reg, m_table_full_reg;

    rule_t         wr_rule, rd_rule;
    logic          wr_en, rd_en;
    logic [AW-1:0] rd_addr;
    logic          is_add, is_eval, full;
    logic [1:0]    wr_cls;

    assign is_eval = (s_func == FUNC_EVAL);
    assign is_add  = (s_func == FUNC_ADD);
    assign full    = (count_reg == COUNT_MAX);

    always_comb begin
        wr_cls = (s_proto_code <= 8'd3) ? s_proto_code[1:0] : CLS_ALL;
        wr_rule.src_ip         = s_src_addr;
        wr_rule.dst_ip         = s_dst_addr;
        wr_rule.src_port_low   = s_src_port_low;
        wr_rule.src_port_high  = s_src_port_high;
        wr_rule.dst_port_low   = s_dst_port_low;
        wr_rule.dst_port_high  = s_dst_port_high;
        wr_rule.direction      = s_direction;
        wr_rule.proto_cls      = wr_cls;
        wr_rule.src_prefix_len = (s_src_prefix_len > PREFIX_MAX) ? PREFIX_MAX
                                                                 : s_src_prefix_len;
        wr_rule.dst_prefix_len = (s_dst_prefix_len > PREFIX_MAX) ? PREFIX_MAX
                                                                 : s_dst_prefix_len;
        wr_rule.flags          = s_flags;
    end

    assign wr_en   = cmd.accept && is_add && !full;
    assign rd_en   = (cmd.accept && is_eval && (count_reg != '0)) || cmd.rd_next;
    assign rd_addr = cmd.accept ? '0 : idx_reg[AW-1:0];

    pafm_ram #(
        .WIDTH ($bits(rule_t)),
        .DEPTH (MAX_RULES)
    ) u_rules (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_rule),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_rule)
    );

    // rule compare against the latched packet
    logic dir_ok, cls_ok, sa_ok, da_ok, sp_ok, dp_ok;

    always_comb begin
        dir_ok = (rd_rule.direction == DIR_BOTH) || (rd_rule.direction == pkt_dir_reg);
        case (rd_rule.proto_cls)
            CLS_TCP:  cls_ok = (pkt_proto_reg == PROTO_TCP);
            CLS_UDP:  cls_ok = (pkt_proto_reg == PROTO_UDP);
            CLS_ICMP: cls_ok = (pkt_proto_reg == PROTO_ICMP);
            default:  cls_ok = 1'b1;
        endcase
        sa_ok = ((rd_rule.src_ip ^ pkt_sa_reg) & prefix_mask(rd_rule.src_prefix_len)) == '0;
        da_ok = ((rd_rule.dst_ip ^ pkt_da_reg) & prefix_mask(rd_rule.dst_prefix_len)) == '0;
        sp_ok = !rd_rule.flags[FL_SRC_RANGE] ||
                (pkt_fl_reg[PF_L4] && (pkt_sp_reg >= rd_rule.src_port_low)
                                   && (pkt_sp_reg <= rd_rule.src_port_high));
        dp_ok = !rd_rule.flags[FL_DST_RANGE] ||
                (pkt_fl_reg[PF_L4] && (pkt_dp_reg >= rd_rule.dst_port_low)
                                   && (pkt_dp_reg <= rd_rule.dst_port_high));
    end

    assign sts.is_eval    = is_eval;
    assign sts.count_zero = (count_reg == '0);
    assign sts.match      = pkt_fl_reg[PF_IPV4] && dir_ok && cls_ok && sa_ok && da_ok
                            && sp_ok && dp_ok;
    assign sts.scan_end   = (idx_reg == count_reg);
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        count_next = count_reg;
        if (cmd.accept) begin
            if (wr_en) begin
                count_next = count_reg + CW'(1);
            end else if (s_func == FUNC_CLEAR) begin
                count_next = '0;
            end
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.accept) begin
            idx_next = CW'(1);
        end else if (cmd.rd_next) begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg          <= '0;
            idx_reg            <= '0;
            default_action_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cfg_we) begin
                default_action_reg <= cfg_wdata;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pkt_dir_reg     <= s_direction;
            pkt_proto_reg   <= s_proto_code;
            pkt_sa_reg      <= s_src_addr;
            pkt_da_reg      <= s_dst_addr;
            pkt_sp_reg      <= s_src_port_low;
            pkt_dp_reg      <= s_dst_port_low;
            pkt_fl_reg      <= s_flags;
            res_verdict_reg <= is_eval && default_action_reg;
            res_hit_reg     <= 1'b0;
            res_full_reg    <= is_add && full;
        end else if (cmd.set_hit) begin
            res_verdict_reg <= rd_rule.flags[FL_DENY];
            res_hit_reg     <= 1'b1;
        end
        if (cmd.load_out) begin
            m_verdict_reg    <= res_verdict_reg;
            m_rule_hit_reg   <= res_hit_reg;
            m_table_full_reg <= res_full_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_verdict    = m_verdict_reg;
    assign m_rule_hit   = m_rule_hit_reg;
    assign m_table_full = m_table_full_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("rule count above table size");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_next |-> idx_reg < count_reg)
        else $error("scan read past last rule");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");

    a_full_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_table_full_reg) |-> (!m_rule_hit_reg && !m_verdict_reg))
        else $error("table_full with evaluate result");
`endif

endmodule

// ===== rtl/packet_acl_first_match_unit.sv =====
// Evaluate: accept, then one rule tried per cycle (k rules, up to MAX_RULES), then the
//   result is loaded into the output once it is free (k is 0 for an empty table).
// Add, clear and unknown operations: no scan; the result is loaded once the output is free.
// One transaction in flight; the one-rule-per-cycle scan sets the rate while results
//   are taken at once.
// aresetn (sync, active low) empties the table and sets default_action to allow.
module packet_acl_first_match_unit
    import pafm_pkg::*;
#(
    parameter int MAX_RULES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [1:0]  s_direction,
    input  logic [7:0]  s_proto_code,
    input  logic [31:0] s_src_addr,
    input  logic [5:0]  s_src_prefix_len,
    input  logic [31:0] s_dst_addr,
    input  logic [5:0]  s_dst_prefix_len,
    input  logic [15:0] s_src_port_low,
    input  logic [15:0] s_src_port_high,
    input  logic [15:0] s_dst_port_low,
    input  logic [15:0] s_dst_port_high,
    input  logic [2:0]  s_flags,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_verdict,
    output logic        m_rule_hit,
    output logic        m_table_full
);

    cmd_t cmd;
    sts_t sts;

    pafm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pafm_dp #(
        .MAX_RULES (MAX_RULES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_func           (s_func),
        .s_direction      (s_direction),
        .s_proto_code     (s_proto_code),
        .s_src_addr       (s_src_addr),
        .s_src_prefix_len (s_src_prefix_len),
        .s_dst_addr       (s_dst_addr),
        .s_dst_prefix_len (s_dst_prefix_len),
        .s_src_port_low   (s_src_port_low),
        .s_src_port_high  (s_src_port_high),
        .s_dst_port_low   (s_dst_port_low),
        .s_dst_port_high  (s_dst_port_high),
        .s_flags          (s_flags),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict        (m_verdict),
        .m_rule_hit       (m_rule_hit),
        .m_table_full     (m_table_full),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule
